/* design/ske_pkg.sv */
`timescale 1ns / 1ps

package ske_pkg;

  localparam int INPUT_FRAC_BITS_DEF = 11;

  localparam int DIST_W  = 16;
  localparam int W_OUT   = 16;
  localparam int MAG_W   = 17;
  localparam int KT_W    = 4;
  localparam int Q_W     = 31;
  localparam int PROD_W  = 62;

  // stages from the magnitude register to the kernel result
  localparam int KERNEL_LAT = 33;

  // largest weight any kernel can give (triweight at zero)
  localparam logic [W_OUT-1:0] W_MAX = 16'd35840;

  localparam logic [KT_W-1:0] KT_RESET    = 4'd1;
  localparam logic [KT_W-1:0] KT_EPAN     = 4'd2;
  localparam logic [KT_W-1:0] KT_BIWEIGHT = 4'd3;
  localparam logic [KT_W-1:0] KT_TRIWGT   = 4'd4;
  localparam logic [KT_W-1:0] KT_TRICUBE  = 4'd5;
  localparam logic [KT_W-1:0] KT_COSINE   = 4'd6;
  localparam logic [KT_W-1:0] KT_UNIFORM  = 4'd7;
  localparam logic [KT_W-1:0] KT_TRIANGLE = 4'd8;

  localparam logic [Q_W-1:0] ONE_Q30        = 31'h4000_0000;
  localparam logic [29:0]    PI_OVER_4_Q30  = 30'd843314857;
  localparam logic [28:0]    INV_SQRT2PI_Q30 = 29'd428361011;
  localparam logic [29:0]    LOG2E_Q29      = 30'd774541003;
  localparam logic [29:0]    LN2_Q30        = 30'd744261118;
  localparam logic [Q_W-1:0] COS_C2  = 31'd1324675879;
  localparam logic [Q_W-1:0] COS_C4  = 31'd272375560;
  localparam logic [Q_W-1:0] COS_C6  = 31'd22401992;
  localparam logic [Q_W-1:0] COS_C8  = 31'd987048;
  localparam logic [Q_W-1:0] COS_C10 = 31'd27060;

  localparam logic [W_OUT-1:0] UNIFORM_W = 16'd16384;

  // q30 product rounded to nearest
  function automatic logic [Q_W-1:0] rnd_q30(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p + (PROD_W'(1) << 29);
    return s[60:30];
  endfunction

  // subtract clamped at zero
  function automatic logic [Q_W-1:0] csub(input logic [Q_W-1:0] c,
                                          input logic [Q_W-1:0] x);
    return (x > c) ? '0 : (c - x);
  endfunction

endpackage

/* design/ske_divk.sv */
`timescale 1ns / 1ps

module ske_divk #(
  parameter int W = 31,
  parameter int K = 3
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] v,
  output logic [W-1:0] quo
);
  localparam int S  = W + 4;
  localparam int MW = S + 1;
  localparam logic [MW-1:0] M  = MW'((65'd1 << S) / K);
  localparam logic [W-1:0]  KV = W'(K);

  logic [W+MW-1:0] prodm;
  logic [W-1:0]    qhat;
  logic [W-1:0]    v1;
  logic [W-1:0]    rem;

  // reciprocal estimate, low by at most one
  assign prodm = (W+MW)'(v) * (W+MW)'(M);
  assign rem   = v1 - (qhat * KV);

  always_ff @(posedge clk) begin
    if (en) begin
      qhat <= prodm[S +: W];
      v1   <= v;
      quo  <= (rem >= KV) ? (qhat + W'(1)) : qhat;
    end
  end

endmodule

/* design/ske_compact.sv */
`timescale 1ns / 1ps

module ske_compact #(
  parameter int FRAC = ske_pkg::INPUT_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ske_pkg::MAG_W-1:0]  a,
  input  logic [ske_pkg::KT_W-1:0]   ktype,
  output logic [ske_pkg::W_OUT-1:0]  w
);
  import ske_pkg::*;

  localparam int TSH = 30 - FRAC;
  localparam logic [MAG_W-1:0] A_ONE = MAG_W'(1) << FRAC;
  localparam int SEL_STAGE = 9;

  typedef struct packed {
    logic             outside;
    logic [W_OUT-1:0] tri_w;
    logic [W_OUT-1:0] epan_w;
    logic [W_OUT-1:0] bi_w;
    logic [W_OUT-1:0] tw_w;
  } cmp_carry_t;

  logic [Q_W-1:0] t_in;
  logic [Q_W-1:0] t1, t_2, t2_2, t2_3, t2_4, t2_5, t2_6;
  logic           out1, out2;
  logic [PROD_W-1:0] tt1;
  logic [Q_W-1:0] v3c, v3;
  logic [PROD_W-1:0] vv3, tt3, cp3;
  logic [Q_W-1:0] tri_s;
  logic [32:0]    ep_s;
  cmp_carry_t     cr3, cr4, cr5, cr6, cr7, cr8;
  logic [Q_W-1:0] v2c, cc, p1;
  logic [34:0]    bi_s;
  logic [PROD_W-1:0] vvv4, cc4, cp4;
  logic [Q_W-1:0] c4;
  logic [36:0]    tw_s;
  logic [Q_W-1:0] c2, p2;
  logic [PROD_W-1:0] ccc5, cp5;
  logic [Q_W-1:0] c3, p3;
  logic [36:0]    num_s;
  logic [21:0]    num6, tric;
  logic [PROD_W-1:0] cp6, cp7;
  logic [Q_W-1:0] p4, p5;
  logic [60:0]    m8, cos_s;
  logic [W_OUT-1:0] sel_w;
  logic [W_OUT-1:0] dly [SEL_STAGE:KERNEL_LAT];

  assign t_in  = Q_W'(a) << TSH;
  assign v3c   = ONE_Q30 - t2_2;
  assign tri_s = (ONE_Q30 - t_2) + 31'd16384;
  assign ep_s  = 33'(v3c) * 33'd3 + 33'd65536;
  assign v2c   = rnd_q30(vv3);
  assign cc    = ONE_Q30 - rnd_q30(tt3);
  assign p1    = csub(COS_C8, rnd_q30(cp3));
  assign bi_s  = 35'(v2c) * 35'd15 + 35'd262144;
  assign tw_s  = 37'(rnd_q30(vvv4)) * 37'd35 + 37'd524288;
  assign c2    = rnd_q30(cc4);
  assign p2    = csub(COS_C6, rnd_q30(cp4));
  assign c3    = rnd_q30(ccc5);
  assign num_s = 37'(c3) * 37'd70 + 37'd1327104;
  assign p3    = csub(COS_C4, rnd_q30(cp5));
  assign p4    = csub(COS_C2, rnd_q30(cp6));
  assign p5    = csub(ONE_Q30, rnd_q30(cp7));
  assign cos_s = m8 + (61'd1 << 44);

  always_ff @(posedge clk) begin
    if (en) begin
      // square of the distance
      t1   <= t_in;
      out1 <= a > A_ONE;
      tt1  <= PROD_W'(t_in) * PROD_W'(t_in);
      t2_2 <= rnd_q30(tt1);
      t_2  <= t1;
      out2 <= out1;
      // 1 - z^2 and first products
      v3   <= v3c;
      vv3  <= PROD_W'(v3c) * PROD_W'(v3c);
      tt3  <= PROD_W'(t2_2) * PROD_W'(t_2);
      cp3  <= PROD_W'(t2_2) * PROD_W'(COS_C10);
      t2_3 <= t2_2;
      cr3.outside <= out2;
      cr3.tri_w   <= tri_s[30:15];
      cr3.epan_w  <= ep_s[32:17];
      cr3.bi_w    <= '0;
      cr3.tw_w    <= '0;
      // powers for biweight, triweight, tricube; cosine series
      cr4       <= '{outside: cr3.outside, tri_w: cr3.tri_w, epan_w: cr3.epan_w,
                     bi_w: bi_s[34:19], tw_w: cr3.tw_w};
      vvv4      <= PROD_W'(v2c) * PROD_W'(v3);
      c4        <= cc;
      cc4       <= PROD_W'(cc) * PROD_W'(cc);
      cp4       <= PROD_W'(t2_3) * PROD_W'(p1);
      t2_4      <= t2_3;
      cr5       <= '{outside: cr4.outside, tri_w: cr4.tri_w, epan_w: cr4.epan_w,
                     bi_w: cr4.bi_w, tw_w: tw_s[35:20]};
      ccc5      <= PROD_W'(c2) * PROD_W'(c4);
      cp5       <= PROD_W'(t2_4) * PROD_W'(p2);
      t2_5      <= t2_4;
      cr6       <= cr5;
      num6      <= num_s[36:15];
      cp6       <= PROD_W'(t2_5) * PROD_W'(p3);
      t2_6      <= t2_5;
      cr7       <= cr6;
      cp7       <= PROD_W'(t2_6) * PROD_W'(p4);
      cr8       <= cr7;
      m8        <= 61'(p5) * 61'(PI_OVER_4_Q30);
      dly[SEL_STAGE] <= sel_w;
    end
  end

  // tricube scaling by 1/81 over two stages
  ske_divk #(.W(22), .K(81)) u_div81 (
    .clk (clk),
    .en  (en),
    .v   (num6),
    .quo (tric)
  );

  always_comb begin
    sel_w = '0;
    if (!cr8.outside) begin
      case (ktype)
        KT_EPAN:     sel_w = cr8.epan_w;
        KT_BIWEIGHT: sel_w = cr8.bi_w;
        KT_TRIWGT:   sel_w = cr8.tw_w;
        KT_TRICUBE:  sel_w = tric[15:0];
        KT_COSINE:   sel_w = cos_s[60:45];
        KT_UNIFORM:  sel_w = UNIFORM_W;
        KT_TRIANGLE: sel_w = cr8.tri_w;
        default:     sel_w = '0;
      endcase
    end
  end

  // line up with the gaussian path
  for (genvar j = SEL_STAGE + 1; j <= KERNEL_LAT; j++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        dly[j] <= dly[j-1];
      end
    end
  end

  assign w = dly[KERNEL_LAT];

endmodule

/* design/ske_gauss.sv */
`timescale 1ns / 1ps

module ske_gauss #(
  parameter int FRAC = ske_pkg::INPUT_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [ske_pkg::MAG_W-1:0] a,
  output logic [ske_pkg::W_OUT-1:0] w
);
  import ske_pkg::*;

  localparam int SH  = 29 - 2 * FRAC;
  localparam int QW  = Q_W + SH;
  localparam int QHW = QW - 17;
  localparam int G_LAST = 28;
  localparam int N_LAST = KERNEL_LAT - 1;

  logic [33:0]        sq_full;
  logic [Q_W-1:0]     sq1;
  logic [QW-1:0]      q;
  logic               far2, far3;
  logic [46:0]        pl2;
  logic [QHW+29:0]    ph2;
  logic [63:0]        ys;
  logic [3:0]         n3;
  logic [29:0]        f3;
  logic [59:0]        gs;
  logic [29:0]        gc [4:G_LAST];
  logic [3:0]         nc [4:N_LAST];
  logic               fc [4:N_LAST];
  logic [Q_W-1:0]     qc [0:9];
  logic [Q_W-1:0]     pf;
  logic [59:0]        m32;
  logic [60:0]        sum;
  logic [60:0]        w_s;

  assign sq_full = 34'(a) * 34'(a);
  assign q       = QW'(sq1) << SH;
  assign ys      = (64'(ph2) << 17) + 64'(pl2) + (64'd1 << 28);
  assign gs      = 60'(f3) * 60'(LN2_Q30) + (60'd1 << 29);
  assign qc[0]   = '0;
  assign pf      = ONE_Q30 - qc[9];
  assign sum     = 61'(m32) + (61'd1 << (6'd44 + 6'(nc[N_LAST])));
  assign w_s     = sum >> (6'd45 + 6'(nc[N_LAST]));

  always_ff @(posedge clk) begin
    if (en) begin
      sq1   <= sq_full[30:0];
      // q = z^2/2, times log2(e) in two halves
      far2  <= 64'(q) >= (64'd11 << 30);
      pl2   <= 47'(q[16:0]) * 47'(LOG2E_Q29);
      ph2   <= (QHW+30)'(q[QW-1:17]) * (QHW+30)'(LOG2E_Q29);
      far3  <= far2;
      n3    <= ys[62:59];
      f3    <= ys[58:29];
      gc[4] <= gs[59:30];
      nc[4] <= n3;
      fc[4] <= far3;
      m32   <= 60'(pf) * 60'(INV_SQRT2PI_Q30);
      w     <= fc[N_LAST] ? '0 : w_s[15:0];
    end
  end

  for (genvar j = 5; j <= G_LAST; j++) begin : g_gc
    always_ff @(posedge clk) begin
      if (en) begin
        gc[j] <= gc[j-1];
      end
    end
  end

  for (genvar j = 5; j <= N_LAST; j++) begin : g_nc
    always_ff @(posedge clk) begin
      if (en) begin
        nc[j] <= nc[j-1];
        fc[j] <= fc[j-1];
      end
    end
  end

  // series for exp(-g), one term each three stages
  for (genvar s = 0; s < 9; s++) begin : g_step
    localparam int K = 9 - s;
    localparam int B = 5 + 3 * s;
    logic [Q_W-1:0] pv;
    logic [60:0]    prod;

    assign pv = ONE_Q30 - qc[s];

    always_ff @(posedge clk) begin
      if (en) begin
        prod <= 61'(gc[B-1]) * 61'(pv) + (61'(K) << 29);
      end
    end

    ske_divk #(.W(Q_W), .K(K)) u_div (
      .clk (clk),
      .en  (en),
      .v   (prod[60:30]),
      .quo (qc[s+1])
    );
  end

endmodule

/* design/smoothing_kernel_evaluator_unit.sv */
`timescale 1ns / 1ps

// channel    dir   handshake                       word
// distance   in    distance_valid / distance_stall distance, signed, 11 fraction bits
// weight     out   weight_valid / weight_stall     weight, unsigned q1.15
// cfg        in    cfg_valid / cfg_ready           kernel_type, 4 bits
//
// one word in and one word out per cycle while weight is not stalled; the pipe depth is
// set by the gaussian path (nine series terms of three stages each)
// rst is synchronous and clears the valid bits, the skid entry and kernel_type (to 1)
// a stall on weight is caught by a one-word skid entry, so the pipe keeps moving until it fills;
// distance_stall is simply the skid entry being full

module smoothing_kernel_evaluator_unit #(
  parameter int INPUT_FRAC_BITS = ske_pkg::INPUT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              distance_valid,
  output logic                              distance_stall,
  input  logic signed [ske_pkg::DIST_W-1:0] distance,
  output logic                              weight_valid,
  input  logic                              weight_stall,
  output logic [ske_pkg::W_OUT-1:0]         weight,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ske_pkg::KT_W-1:0]          kernel_type
);
  import ske_pkg::*;

  localparam int LAST = KERNEL_LAT;

  logic [KT_W-1:0]  ktype;
  logic [LAST:0]    vld;
  logic             adv;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] a0;
  logic [W_OUT-1:0] cw, gw;
  logic [W_OUT-1:0] sel_w;
  logic             is_compact;
  logic             sk_full;
  logic [W_OUT-1:0] sk_w;

  // the pipe moves whenever the skid entry is free
  assign adv            = !sk_full;
  assign distance_stall = sk_full;
  assign cfg_ready      = 1'b1;

  // |z|; the most negative code gives 32768
  assign mag = 17'd0 - {distance[DIST_W-1], distance};
  assign is_compact = ktype inside {[KT_EPAN:KT_TRIANGLE]};
  assign sel_w = is_compact ? cw : gw;

  always_ff @(posedge clk) begin
    if (rst) begin
      ktype <= KT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ktype <= kernel_type;
    end
  end

  // valid bits travel beside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], distance_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a0 <= distance[DIST_W-1] ? mag : {1'b0, distance};
    end
  end

  ske_compact #(.FRAC(INPUT_FRAC_BITS)) u_compact (
    .clk   (clk),
    .en    (adv),
    .a     (a0),
    .ktype (ktype),
    .w     (cw)
  );

  ske_gauss #(.FRAC(INPUT_FRAC_BITS)) u_gauss (
    .clk (clk),
    .en  (adv),
    .a   (a0),
    .w   (gw)
  );

  // output register with a one-word skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_valid <= 1'b0;
      sk_full      <= 1'b0;
    end else if (!weight_valid || !weight_stall) begin
      if (sk_full) begin
        weight_valid <= 1'b1;
        sk_full      <= 1'b0;
      end else begin
        weight_valid <= vld[LAST];
      end
    end else if (vld[LAST] && adv) begin
      sk_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!weight_valid || !weight_stall) begin
      weight <= sk_full ? sk_w : sel_w;
    end else if (vld[LAST] && adv) begin
      sk_w <= sel_w;
    end
  end

endmodule

/* design/ske_check.sv */
`timescale 1ns / 1ps

module ske_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              distance_valid,
  input logic                              distance_stall,
  input logic signed [ske_pkg::DIST_W-1:0] distance,
  input logic                              weight_valid,
  input logic                              weight_stall,
  input logic [ske_pkg::W_OUT-1:0]         weight,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [ske_pkg::KT_W-1:0]          kernel_type
);
  import ske_pkg::*;

  // nothing comes out the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !weight_valid)
    else $error("weight valid after reset");

  // a held word keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    weight_valid && weight_stall |=> weight_valid && $stable(weight))
    else $error("stalled weight changed");

  // no kernel exceeds the triweight peak
  a_bound: assert property (@(posedge clk) disable iff (rst)
    weight_valid |-> weight <= W_MAX)
    else $error("weight above kernel maximum");

  // input only backs up when a word is waiting at the output
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !weight_valid |-> !distance_stall)
    else $error("input stalled with empty output");

endmodule

bind smoothing_kernel_evaluator_unit ske_check u_check (.*);

/* tb/smoothing_kernel_evaluator_unit_test.sv */
`timescale 1ns / 1ps

// scoreboard: holds the weights still owed by the block, in order
class weight_scoreboard;
  logic [15:0] owed[$];
  int errors = 0;

  // note an accepted distance word with the kernel selected at that time
  function void note_distance(logic [15:0] expected);
    owed.push_back(expected);
  endfunction

  function void check_weight(logic [15:0] got);
    logic [15:0] want;
    if (owed.size() == 0) begin
      $error("weight word with nothing owed: actual %0d", got);
      errors++;
    end else begin
      want = owed.pop_front();
      if (want !== got) begin
        $error("weight mismatch: expected %0d actual %0d", want, got);
        errors++;
      end
    end
  endfunction
endclass

module smoothing_kernel_evaluator_unit_test;
  import ske_pkg::*;

  localparam int FRAC = 11;
  localparam longint ONE = 64'd1 << 30;
  localparam longint HALF = 64'd1 << 29;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic distance_valid = 1'b0;
  logic distance_stall;
  logic signed [15:0] distance = '0;
  logic weight_valid;
  logic weight_stall = 1'b0;
  logic [15:0] weight;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] kernel_type = '0;

  logic [3:0] shape;        // predictor's copy of the kernel register
  bit quiet = 0;            // no idling on either side
  bit sending = 0;
  int idle_cycles = 0;
  weight_scoreboard board;

  smoothing_kernel_evaluator_unit dut (
    .clk(clk), .rst(rst),
    .distance_valid(distance_valid), .distance_stall(distance_stall), .distance(distance),
    .weight_valid(weight_valid), .weight_stall(weight_stall), .weight(weight),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .kernel_type(kernel_type)
  );

  always #2 clk = ~clk;

  function automatic longint unsigned qmul(longint unsigned x, longint unsigned y);
    return (x * y + HALF) >> 30;
  endfunction

  // clamped horner step for the cosine series
  function automatic longint cos_term(longint c, longint x2, longint p);
    longint r;
    r = c - longint'((longint'(x2) * p + HALF) >>> 30);
    return r < 0 ? 0 : r;
  endfunction

  function automatic longint unsigned gauss_weight(longint unsigned a);
    longint unsigned q, y, f, g, p, den;
    int n;
    q = (a * a) << (29 - 2 * FRAC);
    if (q >= 11 * ONE) return 0;
    y = (q * longint'(LOG2E_Q29) + (64'd1 << 28)) >> 29;
    n = int'(y >> 30);
    f = y & (ONE - 1);
    g = qmul(f, longint'(LN2_Q30));
    p = ONE;
    for (int k = 9; k >= 1; k--) begin
      den = longint'(k) << 30;
      p = ONE - (g * p + den / 2) / den;
    end
    return (p * longint'(INV_SQRT2PI_Q30) + (64'd1 << (44 + n))) >> (45 + n);
  endfunction

  // kernel weight for one distance under the current shape
  function automatic logic [15:0] kernel_weight(logic [15:0] raw);
    longint unsigned a, t, t2, v, v2, c, w;
    longint p;
    a = raw[15] ? (64'h10000 - raw) : raw;
    if (shape < KT_EPAN || shape > KT_TRIANGLE) w = gauss_weight(a);
    else if (a > (64'd1 << FRAC)) w = 0;
    else begin
      t = a << (30 - FRAC);
      t2 = qmul(t, t);
      v = ONE - t2;
      case (shape)
        KT_EPAN: w = (3 * v + (64'd1 << 16)) >> 17;
        KT_BIWEIGHT: begin
          v2 = qmul(v, v);
          w = (15 * v2 + (64'd1 << 18)) >> 19;
        end
        KT_TRIWGT: begin
          v2 = qmul(v, v);
          w = (35 * qmul(v2, v) + (64'd1 << 19)) >> 20;
        end
        KT_TRICUBE: begin
          c = ONE - qmul(t2, t);
          c = qmul(qmul(c, c), c);
          w = (70 * c + 81 * (64'd1 << 14)) / (81 * (64'd1 << 15));
        end
        KT_COSINE: begin
          p = cos_term(COS_C8, t2, COS_C10);
          p = cos_term(COS_C6, t2, p);
          p = cos_term(COS_C4, t2, p);
          p = cos_term(COS_C2, t2, p);
          p = cos_term(ONE, t2, p);
          w = (longint'(p) * longint'(PI_OVER_4_Q30) + (64'd1 << 44)) >> 45;
        end
        KT_UNIFORM: w = 16384;
        default: w = ((ONE - t) + (64'd1 << 14)) >> 15;
      endcase
    end
    return w > 65535 ? 16'hFFFF : w[15:0];
  endfunction

  // output side: check on accepted words, stall in random bursts
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (!rst && weight_valid && !weight_stall) board.check_weight(weight);
      @(negedge clk);
      if (burst > 0) burst--;
      else if (!quiet && $urandom_range(0, 9) == 0) burst = $urandom_range(1, 7);
      weight_stall <= (burst > 0) && !quiet;
    end
  end

  // watchdog: cycles in which no word moves on either channel
  always @(posedge clk) begin
    if ((distance_valid && !distance_stall) || (weight_valid && !weight_stall))
      idle_cycles <= 0;
    else if (!rst && (sending || board.owed.size() != 0)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_shape(logic [3:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    kernel_type <= value;
    do @(posedge clk); while (!cfg_ready);
    shape = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // present one distance word, with an optional random gap before it
  task automatic send_distance(logic [15:0] value);
    int gap;
    gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      distance_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    distance_valid <= 1'b1;
    distance <= value;
    do @(posedge clk); while (distance_stall);
    board.note_distance(kernel_weight(value));
    @(negedge clk);
  endtask

  // wait until every owed weight has come back and the pipe has drained
  task automatic drain();
    distance_valid <= 1'b0;
    sending = 0;
    while (board.owed.size() != 0) @(negedge clk);
    repeat (KERNEL_LAT + 10) @(negedge clk);
  endtask

  // random distance: mostly inside the support, some across the whole range
  function automatic logic [15:0] pick_distance();
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom);
      2: return 16'($urandom_range(2040, 2056)) ^ ($urandom_range(0, 1) ? 16'hFFFF : 16'h0);
      default: return 16'($signed(17'($urandom_range(0, 4096)) - 17'sd2048));
    endcase
  endfunction

  initial begin
    logic [15:0] edges[$];
    logic [3:0] shapes[$];
    board = new();
    shape = KT_RESET;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    sending = 1;

    // directed: reset shape (gaussian) on boundary values and tails
    edges = '{16'h0000, 16'h0001, 16'hFFFF, 16'h0800, 16'hF800, 16'h0801, 16'hF7FF,
              16'h7FFF, 16'h8000, 16'h8001, 16'h12C4, 16'h12C3, 16'h1000, 16'h0400};
    foreach (edges[i]) send_distance(edges[i]);
    drain();

    // every shape, the extremes of the register included
    shapes = '{4'd0, KT_EPAN, KT_BIWEIGHT, KT_TRIWGT, KT_TRICUBE, KT_COSINE, KT_UNIFORM,
               KT_TRIANGLE, 4'd9, 4'd15};
    foreach (shapes[s]) begin
      write_shape(shapes[s]);
      sending = 1;
      for (int i = 0; i < 8; i++) send_distance(edges[$urandom_range(0, edges.size() - 1)]);
      drain();
    end

    // random: shape changes between phases, last phase with no idling
    for (int ph = 0; ph < 10; ph++) begin
      write_shape(ph == 9 ? KT_TRIWGT : 4'($urandom_range(0, 15)));
      quiet = (ph == 9);
      sending = 1;
      for (int i = 0; i < 110; i++) send_distance(pick_distance());
      drain();
    end

    if (board.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
